>>> design/mtpe_pkg.sv
// Shared types and codes for the mission transfer protocol engine.
// No dependencies; every other design file imports this package.
package mtpe_pkg;

  // Width of the wrapping sequence counter used for item requests
  localparam int SEQ_BITS = 16;

  // Input opcodes
  localparam logic [3:0] OP_START_DOWNLOAD = 4'd0;
  localparam logic [3:0] OP_START_UPLOAD   = 4'd1;
  localparam logic [3:0] OP_CLEAR          = 4'd2;
  localparam logic [3:0] OP_RX_COUNT       = 4'd3;
  localparam logic [3:0] OP_RX_ITEM        = 4'd4;
  localparam logic [3:0] OP_RX_REQUEST     = 4'd5;
  localparam logic [3:0] OP_RX_ACK         = 4'd6;
  localparam logic [3:0] OP_RX_REACHED     = 4'd7;
  localparam logic [3:0] OP_TICK           = 4'd8;
  localparam logic [3:0] OP_LINK_LOST      = 4'd9;

  // Request classes handed from the front end to the back end
  localparam logic [3:0] CL_NOP       = 4'd0;
  localparam logic [3:0] CL_START_DL  = 4'd1;
  localparam logic [3:0] CL_START_UL  = 4'd2;
  localparam logic [3:0] CL_CLEAR     = 4'd3;
  localparam logic [3:0] CL_COUNT     = 4'd4;
  localparam logic [3:0] CL_ITEM      = 4'd5;
  localparam logic [3:0] CL_REQUEST   = 4'd6;
  localparam logic [3:0] CL_ACK       = 4'd7;
  localparam logic [3:0] CL_REACHED   = 4'd8;
  localparam logic [3:0] CL_TICK      = 4'd9;
  localparam logic [3:0] CL_LINK_LOST = 4'd10;

  // Outgoing message kinds
  localparam logic [2:0] TX_NONE        = 3'd0;
  localparam logic [2:0] TX_REQ_LIST    = 3'd1;
  localparam logic [2:0] TX_REQ_ITEM    = 3'd2;
  localparam logic [2:0] TX_ACK_OK      = 3'd3;
  localparam logic [2:0] TX_SEND_COUNT  = 3'd4;
  localparam logic [2:0] TX_SEND_ITEM   = 3'd5;
  localparam logic [2:0] TX_SET_CURRENT = 3'd6;

  // Warnings
  localparam logic [2:0] WARN_NONE    = 3'd0;
  localparam logic [2:0] WARN_DL_BUSY = 3'd1;
  localparam logic [2:0] WARN_UL_BUSY = 3'd2;
  localparam logic [2:0] WARN_DL_NONE = 3'd3;
  localparam logic [2:0] WARN_UL_NONE = 3'd4;

  // Transfer events
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_SIZE     = 2'd1;
  localparam logic [1:0] EV_COMPLETE = 2'd2;
  localparam logic [1:0] EV_FAILED   = 2'd3;

  // Download phases
  localparam logic [1:0] DL_IDLE = 2'd0;
  localparam logic [1:0] DL_LIST = 2'd1;
  localparam logic [1:0] DL_ITEM = 2'd2;

  // Upload phases
  localparam logic [1:0] UL_IDLE  = 2'd0;
  localparam logic [1:0] UL_COUNT = 2'd1;
  localparam logic [1:0] UL_AWAIT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DL_WAIT = 2'd0;
  localparam logic [1:0] CFG_UL_WAIT = 2'd1;
  localparam logic [1:0] CFG_RETRY   = 2'd2;

  // Configuration reset values
  localparam logic [15:0] DL_WAIT_RESET = 16'd1000;
  localparam logic [15:0] UL_WAIT_RESET = 16'd1000;
  localparam logic [2:0]  RETRY_RESET   = 3'd5;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] seq_number;
    logic [15:0] item_total;
    logic [7:0]  ack_result;
  } item_t;

  typedef struct packed {
    logic [2:0]  tx_kind;
    logic [15:0] tx_seq;
    logic [15:0] tx_count;
    logic [2:0]  warning;
    logic [1:0]  download_event;
    logic [1:0]  upload_event;
    logic        ack_rejected;
    logic [7:0]  ack_code;
    logic        mission_done;
    logic        clear_store;
    logic [15:0] progress_count;
  } result_t;

  // Classified request as held in the queue
  typedef struct packed {
    logic [3:0]          cls;
    logic [15:0]         seq_number;
    logic [SEQ_BITS-1:0] seq_next;
    logic [15:0]         item_total;
    logic [7:0]          ack_result;
    logic                ack_ok;
  } cmd_t;

endpackage

>>> design/mtpe_front.sv
// Front end: classifies an incoming request and precomputes its derived fields.
// Depends on mtpe_pkg.
module mtpe_front
  import mtpe_pkg::*;
(
  input  item_t item,
  output cmd_t  cmd
);

  // Map opcode to request class; unused codes become CL_NOP and do nothing.
  // Carry the payload and precompute the next sequence and ack status.
  always_comb begin
    case (item.opcode)
      OP_START_DOWNLOAD: cmd.cls = CL_START_DL;
      OP_START_UPLOAD:   cmd.cls = CL_START_UL;
      OP_CLEAR:          cmd.cls = CL_CLEAR;
      OP_RX_COUNT:       cmd.cls = CL_COUNT;
      OP_RX_ITEM:        cmd.cls = CL_ITEM;
      OP_RX_REQUEST:     cmd.cls = CL_REQUEST;
      OP_RX_ACK:         cmd.cls = CL_ACK;
      OP_RX_REACHED:     cmd.cls = CL_REACHED;
      OP_TICK:           cmd.cls = CL_TICK;
      OP_LINK_LOST:      cmd.cls = CL_LINK_LOST;
      default:           cmd.cls = CL_NOP;
    endcase
    cmd.seq_number = item.seq_number;
    cmd.seq_next   = item.seq_number[SEQ_BITS-1:0] + {{(SEQ_BITS-1){1'b0}}, 1'b1};
    cmd.item_total = item.item_total;
    cmd.ack_result = item.ack_result;
    cmd.ack_ok     = (item.ack_result == 8'd0);
  end

endmodule

>>> design/mtpe_queue.sv
// Two-entry queue between the front and back ends of the engine.
// Depends on mtpe_pkg for the queued request type.
module mtpe_queue
  import mtpe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Store a pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

endmodule

>>> design/mtpe_back.sv
// Back end: transfer state, timers, configuration and the result register.
// Depends on mtpe_pkg.
module mtpe_back
  import mtpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  // Configuration
  logic [15:0] dl_wait;
  logic [15:0] ul_wait;
  logic [2:0]  retry_limit;

  // Transfer state
  logic [1:0]          dl_phase, dl_phase_next;
  logic [1:0]          ul_phase, ul_phase_next;
  logic [2:0]          dl_tries, dl_tries_next;
  logic [2:0]          ul_tries, ul_tries_next;
  logic                pend_valid, pend_valid_next;
  logic [SEQ_BITS-1:0] pend_seq, pend_seq_next;
  logic [15:0]         announced, announced_next;
  logic [15:0]         received, received_next;
  logic [15:0]         outgoing, outgoing_next;
  logic [15:0]         dl_timer, dl_timer_next;
  logic [15:0]         ul_timer, ul_timer_next;
  logic                dl_run, dl_run_next;
  logic                ul_run, ul_run_next;

  result_t     res;
  logic [16:0] dl_sum;
  logic [16:0] ul_sum;

  // Take a request whenever the result register is free or draining
  assign pop = head_valid && (!result_valid || !result_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dl_wait     <= DL_WAIT_RESET;
      ul_wait     <= UL_WAIT_RESET;
      retry_limit <= RETRY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DL_WAIT: dl_wait     <= cfg_data;
        CFG_UL_WAIT: ul_wait     <= cfg_data;
        CFG_RETRY:   retry_limit <= cfg_data[2:0];
        default:     ;
      endcase
    end
  end

  // Next state and result for the request at the queue head
  always_comb begin
    dl_phase_next   = dl_phase;
    ul_phase_next   = ul_phase;
    dl_tries_next   = dl_tries;
    ul_tries_next   = ul_tries;
    pend_valid_next = pend_valid;
    pend_seq_next   = pend_seq;
    announced_next  = announced;
    received_next   = received;
    outgoing_next   = outgoing;
    dl_timer_next   = dl_timer;
    ul_timer_next   = ul_timer;
    dl_run_next     = dl_run;
    ul_run_next     = ul_run;
    dl_sum          = {1'b0, dl_timer} + 17'd1;
    ul_sum          = {1'b0, ul_timer} + 17'd1;
    res             = '0;

    case (head.cls)
      CL_START_DL: begin
        if (ul_phase != UL_IDLE) begin
          res.warning = WARN_UL_BUSY;
        end else if (dl_phase != DL_IDLE) begin
          res.warning = WARN_DL_BUSY;
        end else begin
          res.tx_kind   = TX_REQ_LIST;
          dl_phase_next = DL_LIST;
          dl_timer_next = 16'd0;
          dl_run_next   = 1'b1;
        end
      end

      CL_START_UL: begin
        if (dl_phase != DL_IDLE) begin
          res.warning = WARN_DL_BUSY;
        end else if (ul_phase != UL_IDLE) begin
          res.warning = WARN_UL_BUSY;
        end else begin
          res.upload_event = EV_SIZE;
          if (head.item_total == 16'd0) begin
            res.warning = WARN_UL_NONE;
          end else begin
            outgoing_next  = head.item_total;
            res.tx_kind    = TX_SEND_COUNT;
            res.tx_count   = head.item_total;
            ul_phase_next  = UL_COUNT;
            ul_timer_next  = 16'd0;
            ul_run_next    = 1'b1;
          end
        end
      end

      CL_CLEAR: begin
        if (dl_phase != DL_IDLE) begin
          res.warning = WARN_DL_BUSY;
        end else if (ul_phase != UL_IDLE) begin
          res.warning = WARN_UL_BUSY;
        end else begin
          res.clear_store = 1'b1;
          received_next   = 16'd0;
        end
      end

      CL_COUNT: begin
        if (dl_phase == DL_LIST) begin
          announced_next = head.item_total;
          if (head.item_total != 16'd0) begin
            res.clear_store = 1'b1;
            received_next   = 16'd0;
            if (!pend_valid || pend_seq != '0) begin
              pend_valid_next = 1'b1;
              pend_seq_next   = '0;
              dl_tries_next   = 3'd0;
            end
            res.tx_kind   = TX_REQ_ITEM;
            dl_phase_next = DL_ITEM;
            dl_timer_next = 16'd0;
            dl_run_next   = 1'b1;
          end else begin
            dl_timer_next = 16'd0;
            dl_run_next   = 1'b0;
            dl_tries_next = 3'd0;
            dl_phase_next = DL_IDLE;
            res.warning   = WARN_DL_NONE;
          end
          res.download_event = EV_SIZE;
        end
      end

      CL_ITEM: begin
        if (dl_phase == DL_ITEM) begin
          if (received != 16'hFFFF) received_next = received + 16'd1;
          if (received_next == announced) begin
            res.tx_kind        = TX_ACK_OK;
            pend_valid_next    = 1'b0;
            pend_seq_next      = '0;
            dl_tries_next      = 3'd0;
            dl_phase_next      = DL_IDLE;
            dl_timer_next      = 16'd0;
            dl_run_next        = 1'b0;
            res.download_event = EV_COMPLETE;
          end else begin
            if (!pend_valid || pend_seq != head.seq_next) begin
              pend_valid_next = 1'b1;
              pend_seq_next   = head.seq_next;
              dl_tries_next   = 3'd0;
            end
            res.tx_kind   = TX_REQ_ITEM;
            res.tx_seq    = 16'(head.seq_next);
            dl_phase_next = DL_ITEM;
            dl_timer_next = 16'd0;
            dl_run_next   = 1'b1;
          end
        end
      end

      CL_REQUEST: begin
        if (ul_phase != UL_IDLE) begin
          ul_timer_next = 16'd0;
          ul_run_next   = 1'b0;
          if (head.seq_number >= outgoing) begin
            ul_tries_next    = 3'd0;
            ul_phase_next    = UL_IDLE;
            res.upload_event = EV_FAILED;
          end else begin
            res.tx_kind   = TX_SEND_ITEM;
            res.tx_seq    = 16'(head.seq_number[SEQ_BITS-1:0]);
            ul_phase_next = UL_AWAIT;
            ul_run_next   = 1'b1;
          end
        end
      end

      CL_ACK: begin
        if (!head.ack_ok) begin
          res.ack_rejected = 1'b1;
          res.ack_code     = head.ack_result;
        end
        if (ul_phase != UL_IDLE) begin
          ul_tries_next = 3'd0;
          ul_phase_next = UL_IDLE;
          ul_timer_next = 16'd0;
          ul_run_next   = 1'b0;
          if (head.ack_ok) begin
            res.tx_kind      = TX_SET_CURRENT;
            res.upload_event = EV_COMPLETE;
          end else begin
            res.upload_event = EV_FAILED;
          end
        end
      end

      CL_REACHED: begin
        res.mission_done = (announced != 16'd0) &&
                           (head.seq_number == announced - 16'd1);
      end

      CL_TICK: begin
        // Download timer
        if (dl_run) begin
          dl_timer_next = dl_sum[15:0];
          if (dl_sum >= {1'b0, dl_wait}) begin
            dl_timer_next = 16'd0;
            dl_run_next   = 1'b0;
            if (dl_phase == DL_LIST || dl_phase == DL_ITEM) begin
              if (dl_tries < retry_limit) begin
                dl_tries_next = dl_tries + 3'd1;
                if (dl_phase == DL_LIST) begin
                  res.tx_kind = TX_REQ_LIST;
                end else begin
                  if (!pend_valid) begin
                    pend_valid_next = 1'b1;
                    dl_tries_next   = 3'd0;
                  end
                  res.tx_kind = TX_REQ_ITEM;
                  res.tx_seq  = 16'(pend_seq);
                end
                dl_run_next = 1'b1;
              end else begin
                pend_valid_next    = 1'b0;
                pend_seq_next      = '0;
                dl_tries_next      = 3'd0;
                dl_phase_next      = DL_IDLE;
                res.download_event = EV_FAILED;
              end
            end
          end
        end
        // Upload timer
        if (ul_run) begin
          ul_timer_next = ul_sum[15:0];
          if (ul_sum >= {1'b0, ul_wait}) begin
            ul_timer_next = 16'd0;
            ul_run_next   = 1'b0;
            if (ul_phase == UL_COUNT && ul_tries < retry_limit) begin
              ul_tries_next = ul_tries + 3'd1;
              res.tx_kind   = TX_SEND_COUNT;
              res.tx_count  = outgoing;
              ul_run_next   = 1'b1;
            end else if (ul_phase == UL_COUNT || ul_phase == UL_AWAIT) begin
              ul_tries_next    = 3'd0;
              ul_phase_next    = UL_IDLE;
              res.upload_event = EV_FAILED;
            end
          end
        end
      end

      CL_LINK_LOST: begin
        if (dl_phase != DL_IDLE) begin
          pend_valid_next    = 1'b0;
          pend_seq_next      = '0;
          dl_tries_next      = 3'd0;
          dl_phase_next      = DL_IDLE;
          dl_timer_next      = 16'd0;
          dl_run_next        = 1'b0;
          res.download_event = EV_FAILED;
        end
        if (ul_phase != UL_IDLE) begin
          ul_tries_next    = 3'd0;
          ul_phase_next    = UL_IDLE;
          ul_timer_next    = 16'd0;
          ul_run_next      = 1'b0;
          res.upload_event = EV_FAILED;
        end
      end

      default: ;
    endcase

    // Report progress, dropped to zero on a download failure
    res.progress_count = (res.download_event == EV_FAILED) ? 16'd0 : received_next;
  end

  // Commit state on each taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      dl_phase   <= DL_IDLE;
      ul_phase   <= UL_IDLE;
      dl_tries   <= 3'd0;
      ul_tries   <= 3'd0;
      pend_valid <= 1'b0;
      pend_seq   <= '0;
      announced  <= 16'd0;
      received   <= 16'd0;
      outgoing   <= 16'd0;
      dl_timer   <= 16'd0;
      ul_timer   <= 16'd0;
      dl_run     <= 1'b0;
      ul_run     <= 1'b0;
    end else if (pop) begin
      dl_phase   <= dl_phase_next;
      ul_phase   <= ul_phase_next;
      dl_tries   <= dl_tries_next;
      ul_tries   <= ul_tries_next;
      pend_valid <= pend_valid_next;
      pend_seq   <= pend_seq_next;
      announced  <= announced_next;
      received   <= received_next;
      outgoing   <= outgoing_next;
      dl_timer   <= dl_timer_next;
      ul_timer   <= ul_timer_next;
      dl_run     <= dl_run_next;
      ul_run     <= ul_run_next;
    end
  end

  // Result register: load on pop, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res;
    end
  end

endmodule

>>> design/mission_transfer_protocol_engine_unit.sv
// Top level of the mission transfer protocol engine.
// Depends on mtpe_pkg, mtpe_front, mtpe_queue and mtpe_back.
//
//   Channel  Handshake                    Payload
//   item     item_valid / item_stall      item (item_t)
//   result   result_valid / result_stall  result (result_t)
//   cfg      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One request per cycle while result_stall is low; a request is first written
// into the queue, and its result is then loaded into the back end's result
// register, from which it leaves on the result channel.
// The two-entry queue sets how long the input keeps flowing while results stall;
// item_stall rises only when it is full. Reset is synchronous and clears all
// transfer state and loads the register defaults. cfg_ready is always high.
module mission_transfer_protocol_engine_unit
  import mtpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  cmd_t head;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign item_stall = q_full;
  assign cfg_ready  = 1'b1;

  mtpe_front u_front (
    .item (item),
    .cmd  (cmd)
  );

  mtpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (item_valid && !q_full),
    .push_data  (cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (head)
  );

  mtpe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_valid   (q_valid),
    .head         (head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
